@@ sv/frame_receive_validator_unit_defines.svh @@
// Assertion helpers shared by the frame validator RTL.
// Both expect clk and arst_n in the enclosing module.
`ifndef FRAME_RECEIVE_VALIDATOR_UNIT_DEFINES_SVH
`define FRAME_RECEIVE_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FRV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/frv_pkg.sv @@
package frv_pkg;

	localparam int OVERHEAD_BYTES = 8;
	localparam int BYTE_W         = 8;
	localparam int ADDR_W         = 16;
	localparam int SUM_W          = 16;
	localparam int POS_W          = 9;
	localparam int STATUS_W       = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	typedef logic [POS_W-1:0] pos_t;

	// fixed header positions within a frame
	localparam pos_t POS_IDLE    = pos_t'(0);
	localparam pos_t POS_START2  = pos_t'(1);
	localparam pos_t POS_ADDR_LO = pos_t'(2);
	localparam pos_t POS_ADDR_HI = pos_t'(3);
	localparam pos_t POS_CMD     = pos_t'(4);
	localparam pos_t POS_LEN     = pos_t'(5);
	// checksum low byte sits at data length + overhead - 2
	localparam pos_t CSUM_OFFSET = pos_t'(OVERHEAD_BYTES - 2);
	// highest position ever held (checksum high byte of a longest frame)
	localparam pos_t POS_MAX     = pos_t'((1 << BYTE_W) - 1 + OVERHEAD_BYTES - 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_CHECKSUM_ERR  = 3'd1,
		ST_ADDR_MISMATCH = 3'd2,
		ST_UNKNOWN_CMD   = 3'd3,
		ST_HEADER_ERR    = 3'd4
	} status_t;

	typedef enum logic {
		KIND_STATIC  = 1'b0,
		KIND_DYNAMIC = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_FIRST  = 3'd0,
		REG_START_SECOND = 3'd1,
		REG_OWN_ADDRESS  = 3'd2,
		REG_STATIC_CODE  = 3'd3,
		REG_DYNAMIC_CODE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_first;
		logic [BYTE_W-1:0] start_second;
		logic [ADDR_W-1:0] own_address;
		logic [BYTE_W-1:0] static_code;
		logic [BYTE_W-1:0] dynamic_code;
	} cfg_t;

	typedef struct packed {
		logic    frame_done;
		status_t status;
		kind_t   kind;
	} result_t;

endpackage

@@ sv/frv_if.sv @@
interface frv_in_if;
	logic                        valid;
	logic                        ready;
	logic [frv_pkg::BYTE_W-1:0]  rx_byte;
	logic                        restart;

	modport source (output valid, rx_byte, restart, input ready);
	modport sink   (input valid, rx_byte, restart, output ready);
endinterface

interface frv_out_if;
	logic                          valid;
	logic                          ready;
	logic                          frame_done;
	logic [frv_pkg::STATUS_W-1:0]  status;
	logic                          request_kind;

	modport source (output valid, frame_done, status, request_kind, input ready);
	modport sink   (input valid, frame_done, status, request_kind, output ready);
endinterface

interface frv_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [frv_pkg::CFG_IDX_W-1:0]  index;
	logic [frv_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/frame_receive_validator_unit.sv @@
// A byte transferred on rx is held in the input register and checked by the frame checker;
//   its result is then held in the result register, which drives res.valid and the fields.
// Throughput: one byte per cycle while res.ready allows; input register, frame checker, result register.
// Reset (arst_n, async, low): idle, no frame in progress, all config registers zero,
//   both pipeline slots empty.
`include "frame_receive_validator_unit_defines.svh"

module frame_receive_validator_unit (
	input  logic           clk,
	input  logic           arst_n,
	frv_in_if.sink         rx,
	frv_out_if.source      res,
	frv_cfg_if.sink        cfg
);

	// configuration registers
	frv_pkg::cfg_t cfg_q;

	// input stage
	logic                       valid_s1;
	logic [frv_pkg::BYTE_W-1:0] rx_byte_s1;
	logic                       restart_s1;

	// result stage
	logic             out_valid_q;
	frv_pkg::result_t result_q;
	frv_pkg::result_t result_s1;

	logic advance;   // result slot free or being drained this cycle
	logic step;      // byte in stage 1 is processed this cycle

	assign advance  = !out_valid_q || res.ready;
	assign step     = valid_s1 && advance;
	// new byte enters whenever stage 1 is empty or moves on
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// config writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				frv_pkg::REG_START_FIRST:  cfg_q.start_first  <= cfg.data[frv_pkg::BYTE_W-1:0];
				frv_pkg::REG_START_SECOND: cfg_q.start_second <= cfg.data[frv_pkg::BYTE_W-1:0];
				frv_pkg::REG_OWN_ADDRESS:  cfg_q.own_address  <= cfg.data[frv_pkg::ADDR_W-1:0];
				frv_pkg::REG_STATIC_CODE:  cfg_q.static_code  <= cfg.data[frv_pkg::BYTE_W-1:0];
				frv_pkg::REG_DYNAMIC_CODE: cfg_q.dynamic_code <= cfg.data[frv_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 valid: set on a transfer, cleared when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
			restart_s1 <= rx.restart;
		end
	end

	// frame state and per-byte verdict
	frv_frame_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte_s1),
		.restart (restart_s1),
		.cfg     (cfg_q),
		.result  (result_s1)
	);

	// result register: every byte gives exactly one result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result_s1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.frame_done   = result_q.frame_done;
	assign res.status       = result_q.status;
	assign res.request_kind = result_q.kind;

	`FRV_ASSERT_NEXT(a_step_gives_result, step, out_valid_q, "processed byte left no result")
	`FRV_ASSERT_NOW(a_quiet_fields, out_valid_q && !result_q.frame_done, result_q.status == frv_pkg::ST_OK && result_q.kind == frv_pkg::KIND_STATIC, "fields set without frame end")
	`FRV_ASSERT_NOW(a_kind_only_ok, out_valid_q && result_q.status != frv_pkg::ST_OK, result_q.kind == frv_pkg::KIND_STATIC && result_q.frame_done, "error result malformed")

endmodule

@@ sv/frv_frame_check.sv @@
`include "frame_receive_validator_unit_defines.svh"

module frv_frame_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [frv_pkg::BYTE_W-1:0] rx_byte,
	input  logic                       restart,
	input  frv_pkg::cfg_t              cfg,
	output frv_pkg::result_t           result
);

	frv_pkg::pos_t               byte_pos_q, pos, pos_nxt, low_pos;
	logic [frv_pkg::SUM_W-1:0]   sum_q, sum, sum_nxt, csum_got;
	logic [frv_pkg::ADDR_W-1:0]  addr_q, addr, addr_nxt;
	logic [frv_pkg::BYTE_W-1:0]  cmd_q, cmd, cmd_nxt;
	logic [frv_pkg::BYTE_W-1:0]  len_q, len, len_nxt;
	logic [frv_pkg::BYTE_W-1:0]  csum_lo_q, csum_lo, csum_lo_nxt;
	logic                        go_idle;

	// restart wipes the partial frame before the byte is looked at
	always_comb begin
		pos     = restart ? frv_pkg::POS_IDLE : byte_pos_q;
		sum     = restart ? '0 : sum_q;
		addr    = restart ? '0 : addr_q;
		cmd     = restart ? '0 : cmd_q;
		len     = restart ? '0 : len_q;
		csum_lo = restart ? '0 : csum_lo_q;
		low_pos = frv_pkg::pos_t'(len) + frv_pkg::CSUM_OFFSET;
		csum_got = {rx_byte, csum_lo};
	end

	always_comb begin
		pos_nxt     = pos;
		sum_nxt     = sum;
		addr_nxt    = addr;
		cmd_nxt     = cmd;
		len_nxt     = len;
		csum_lo_nxt = csum_lo;
		go_idle     = 1'b0;
		result      = '{frame_done: 1'b0, status: frv_pkg::ST_OK,
			kind: frv_pkg::KIND_STATIC};

		case (pos)
			frv_pkg::POS_IDLE: begin
				if (rx_byte == cfg.start_first) begin
					pos_nxt = pos + 1'b1;
					sum_nxt = sum + frv_pkg::SUM_W'(rx_byte);
				end
			end
			frv_pkg::POS_START2: begin
				if (rx_byte != cfg.start_second) begin
					result.frame_done = 1'b1;
					result.status     = frv_pkg::ST_HEADER_ERR;
					go_idle           = 1'b1;
				end else begin
					pos_nxt = pos + 1'b1;
					sum_nxt = sum + frv_pkg::SUM_W'(rx_byte);
				end
			end
			frv_pkg::POS_ADDR_LO, frv_pkg::POS_ADDR_HI,
			frv_pkg::POS_CMD, frv_pkg::POS_LEN: begin
				pos_nxt = pos + 1'b1;
				sum_nxt = sum + frv_pkg::SUM_W'(rx_byte);
				case (pos)
					frv_pkg::POS_ADDR_LO: addr_nxt = frv_pkg::ADDR_W'(rx_byte);
					frv_pkg::POS_ADDR_HI: addr_nxt = {rx_byte, addr[frv_pkg::BYTE_W-1:0]};
					frv_pkg::POS_CMD:     cmd_nxt  = rx_byte;
					default:              len_nxt  = rx_byte;
				endcase
			end
			default: begin
				if (pos == low_pos) begin
					// checksum low byte is not part of the sum
					csum_lo_nxt = rx_byte;
					pos_nxt     = pos + 1'b1;
				end else if (pos == low_pos + 1'b1) begin
					result.frame_done = 1'b1;
					go_idle           = 1'b1;
					if (csum_got != sum)
						result.status = frv_pkg::ST_CHECKSUM_ERR;
					else if (addr != cfg.own_address)
						result.status = frv_pkg::ST_ADDR_MISMATCH;
					else if (cmd == cfg.static_code)
						result.kind = frv_pkg::KIND_STATIC;
					else if (cmd == cfg.dynamic_code)
						result.kind = frv_pkg::KIND_DYNAMIC;
					else
						result.status = frv_pkg::ST_UNKNOWN_CMD;
				end else begin
					pos_nxt = pos + 1'b1;
					sum_nxt = sum + frv_pkg::SUM_W'(rx_byte);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= frv_pkg::POS_IDLE;
			sum_q      <= '0;
			addr_q     <= '0;
			cmd_q      <= '0;
			len_q      <= '0;
			csum_lo_q  <= '0;
		end else if (step) begin
			if (go_idle) begin
				byte_pos_q <= frv_pkg::POS_IDLE;
				sum_q      <= '0;
				addr_q     <= '0;
				cmd_q      <= '0;
				len_q      <= '0;
				csum_lo_q  <= '0;
			end else begin
				byte_pos_q <= pos_nxt;
				sum_q      <= sum_nxt;
				addr_q     <= addr_nxt;
				cmd_q      <= cmd_nxt;
				len_q      <= len_nxt;
				csum_lo_q  <= csum_lo_nxt;
			end
		end
	end

	`FRV_ASSERT_NEXT(a_done_goes_idle, step && result.frame_done, byte_pos_q == frv_pkg::POS_IDLE, "frame end did not return to idle")
	`FRV_ASSERT_NOW(a_pos_bounded, 1'b1, byte_pos_q <= frv_pkg::POS_MAX, "byte position past longest frame")
	`FRV_ASSERT_NOW(a_idle_sum_clear, byte_pos_q == frv_pkg::POS_IDLE, sum_q == '0, "running sum not clear while idle")

endmodule

@@ test/frame_receive_validator_unit_test.sv @@
`timescale 1ns / 1ps

module frame_receive_validator_unit_test;
	import frv_pkg::*;

	localparam int ITEM_TARGET   = 1100;  // frame bytes in the random part
	localparam int HOLD_CYCLES   = 400;   // long consumer hold-off
	localparam int STALL_LIMIT   = 3000;  // cycles with no transfer at all
	localparam int DIRECTED_ROWS = 25;
	localparam int FIRST_CONFIGURED_ROW = 3;  // rows before this run on reset values

	// one row of the directed table; fixed marks a verdict typed in by hand
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              rs;
		logic              fixed;
		result_t           value;
	} directed_row_t;

	typedef struct packed {
		logic    fixed;
		result_t value;
	} verdict_pin_t;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} drain_mode_t;

	localparam result_t QUIET       = '{frame_done: 1'b0, status: ST_OK, kind: KIND_STATIC};
	localparam result_t HEADER_FAIL = '{frame_done: 1'b1, status: ST_HEADER_ERR,
		kind: KIND_STATIC};
	localparam verdict_pin_t PREDICTED = '{fixed: 1'b0, value: QUIET};

	localparam cfg_t DIRECTED_CFG = '{start_first: 8'hA5, start_second: 8'h5A,
		own_address: 16'h1234, static_code: 8'h01, dynamic_code: 8'h02};

	// Directed stimulus. Rows 0..2 run with every register at reset (all zero);
	// the rest run with DIRECTED_CFG. Frame checksums: 0x0146 and a bad one.
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h33, 1'b0, 1'b1, QUIET},        // idle, not a start byte: ignored
		'{8'h00, 1'b0, 1'b1, QUIET},        // start byte at reset value
		'{8'hFF, 1'b0, 1'b1, HEADER_FAIL},  // wrong second start byte
		'{8'hA5, 1'b0, 1'b1, QUIET},
		'{8'hA5, 1'b0, 1'b1, HEADER_FAIL},  // repeated first byte is a header error
		'{8'h5A, 1'b0, 1'b1, QUIET},        // ...and is not taken as a new start
		'{8'hA5, 1'b0, 1'b0, QUIET},        // ok static frame, no data
		'{8'h5A, 1'b0, 1'b0, QUIET},
		'{8'h34, 1'b0, 1'b0, QUIET},
		'{8'h12, 1'b0, 1'b0, QUIET},
		'{8'h01, 1'b0, 1'b0, QUIET},
		'{8'h00, 1'b0, 1'b0, QUIET},
		'{8'h46, 1'b0, 1'b0, QUIET},
		'{8'h01, 1'b0, 1'b0, QUIET},
		'{8'hA5, 1'b0, 1'b0, QUIET},        // partial frame ...
		'{8'h5A, 1'b0, 1'b0, QUIET},
		'{8'hA5, 1'b1, 1'b0, QUIET},        // ... dropped, same byte starts a new one
		'{8'h5A, 1'b0, 1'b0, QUIET},
		'{8'h34, 1'b0, 1'b0, QUIET},
		'{8'h12, 1'b0, 1'b0, QUIET},
		'{8'h02, 1'b0, 1'b0, QUIET},
		'{8'h01, 1'b0, 1'b0, QUIET},        // one data byte
		'{8'h00, 1'b0, 1'b0, QUIET},
		'{8'h00, 1'b0, 1'b0, QUIET},        // checksum 0x0000: wrong
		'{8'h00, 1'b0, 1'b0, QUIET}
	};

	logic clk = 1'b0;
	logic arst_n;

	frv_in_if  rx_if ();
	frv_out_if res_if ();
	frv_cfg_if cfg_if ();

	frame_receive_validator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Frame checker model: own copy of registers and frame state
	// ---------------------------------------------------------------
	cfg_t              model_regs;
	pos_t              frm_pos;
	logic [SUM_W-1:0]  frm_sum;
	logic [ADDR_W-1:0] frm_addr;
	logic [BYTE_W-1:0] frm_cmd;
	logic [BYTE_W-1:0] frm_len;
	logic [BYTE_W-1:0] frm_csum_lo;

	function automatic void clear_frame();
		frm_pos     = POS_IDLE;
		frm_sum     = '0;
		frm_addr    = '0;
		frm_cmd     = '0;
		frm_len     = '0;
		frm_csum_lo = '0;
	endfunction

	function automatic void take_frame_byte(logic [BYTE_W-1:0] b);
		frm_sum = frm_sum + SUM_W'(b);
		frm_pos = frm_pos + pos_t'(1);
	endfunction

	// verdict for one received byte; advances the model frame state
	function automatic result_t frame_verdict(logic [BYTE_W-1:0] b, logic rs);
		result_t           r;
		pos_t              low_pos;
		logic [SUM_W-1:0]  got;
		r = QUIET;
		if (rs)
			clear_frame();
		// checksum low byte follows the data, high byte ends the frame
		low_pos = pos_t'(frm_len) + CSUM_OFFSET;
		case (frm_pos)
			POS_IDLE: begin
				if (b == model_regs.start_first)
					take_frame_byte(b);
			end
			POS_START2: begin
				if (b != model_regs.start_second) begin
					r.frame_done = 1'b1;
					r.status     = ST_HEADER_ERR;
					clear_frame();
				end else begin
					take_frame_byte(b);
				end
			end
			POS_ADDR_LO: begin
				frm_addr = ADDR_W'(b);
				take_frame_byte(b);
			end
			POS_ADDR_HI: begin
				frm_addr[ADDR_W-1:BYTE_W] = b;
				take_frame_byte(b);
			end
			POS_CMD: begin
				frm_cmd = b;
				take_frame_byte(b);
			end
			POS_LEN: begin
				frm_len = b;
				take_frame_byte(b);
			end
			default: begin
				if (frm_pos == low_pos) begin
					// checksum bytes do not add to the running sum
					frm_csum_lo = b;
					frm_pos     = frm_pos + pos_t'(1);
				end else if (frm_pos == low_pos + pos_t'(1)) begin
					got          = {b, frm_csum_lo};
					r.frame_done = 1'b1;
					// checksum first, then address, then command;
					// equal codes resolve to a static request
					if (got != frm_sum)
						r.status = ST_CHECKSUM_ERR;
					else if (frm_addr != model_regs.own_address)
						r.status = ST_ADDR_MISMATCH;
					else if (frm_cmd == model_regs.static_code)
						r.kind = KIND_STATIC;
					else if (frm_cmd == model_regs.dynamic_code)
						r.kind = KIND_DYNAMIC;
					else
						r.status = ST_UNKNOWN_CMD;
					clear_frame();
				end else begin
					take_frame_byte(b);
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Transfer monitor and result check
	// ---------------------------------------------------------------
	result_t      pending_verdicts [$];  // expected results, oldest first
	verdict_pin_t fixed_verdicts [$];    // one per offered byte, in order
	int           errors       = 0;
	int           stall_cycles = 0;

	always @(posedge clk) begin : transfer_monitor
		result_t      predicted;
		result_t      want;
		verdict_pin_t pin;
		bit           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_if.valid && cfg_if.ready) begin
				moved = 1'b1;
				case (cfg_if.index)
					REG_START_FIRST:  model_regs.start_first  = cfg_if.data[BYTE_W-1:0];
					REG_START_SECOND: model_regs.start_second = cfg_if.data[BYTE_W-1:0];
					REG_OWN_ADDRESS:  model_regs.own_address  = cfg_if.data[ADDR_W-1:0];
					REG_STATIC_CODE:  model_regs.static_code  = cfg_if.data[BYTE_W-1:0];
					REG_DYNAMIC_CODE: model_regs.dynamic_code = cfg_if.data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (rx_if.valid && rx_if.ready) begin
				moved     = 1'b1;
				predicted = frame_verdict(rx_if.rx_byte, rx_if.restart);
				pin       = fixed_verdicts.pop_front();
				pending_verdicts.push_back(pin.fixed ? pin.value : predicted);
			end
			if (res_if.valid && res_if.ready) begin
				moved = 1'b1;
				if (pending_verdicts.size() == 0) begin
					$error("result with nothing expected: frame_done %0d status %0d kind %0d",
						res_if.frame_done, res_if.status, res_if.request_kind);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (res_if.frame_done !== want.frame_done) begin
						$error("frame_done: expected %0d, actual %0d",
							want.frame_done, res_if.frame_done);
						errors++;
					end
					if (res_if.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, res_if.status);
						errors++;
					end
					if (res_if.request_kind !== want.kind) begin
						$error("request_kind: expected %0d, actual %0d",
							want.kind, res_if.request_kind);
						errors++;
					end
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	// watchdog: too long without a single transfer
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result consumer: ready pattern of its own, plus one long hold-off
	// ---------------------------------------------------------------
	logic consumer_hold = 1'b0;

	initial begin : consumer
		drain_mode_t mode;
		int          mode_left;
		bit          hold_taken;
		mode          = RX_FREE;
		mode_left     = 0;
		hold_taken    = 1'b0;
		res_if.ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (consumer_hold && !hold_taken) begin
				// block fills up and must stall its input
				hold_taken = 1'b1;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (!consumer_hold)
				hold_taken = 1'b0;
			if (mode_left == 0) begin
				mode      = drain_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(10, 120);
			end
			mode_left--;
			case (mode)
				RX_FREE:     res_if.ready <= 1'b1;
				RX_COIN:     res_if.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:   res_if.ready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: res_if.ready <= (mode_left % 3 == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Byte source
	// ---------------------------------------------------------------
	int   burst_left    = 0;
	bit   steady_sender = 1'b0;
	bit   restart_next  = 1'b0;  // drop whatever partial frame is left
	int   items_sent    = 0;
	cfg_t phase_cfg;

	// offer one byte, hold it until transferred; bursts with random gaps unless steady_sender is set
	task automatic send_item(logic [BYTE_W-1:0] b, logic rs, verdict_pin_t pin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = steady_sender ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		fixed_verdicts.push_back(pin);
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.restart <= rs | restart_next;
		restart_next = 1'b0;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	// stop offering and wait for every outstanding verdict
	task automatic finish_outstanding();
		rx_if.valid <= 1'b0;
		do @(posedge clk);
		while (pending_verdicts.size() != 0 || fixed_verdicts.size() != 0);
	endtask

	// back-to-back register writes; valid stays up between them
	task automatic write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	task automatic load_registers(cfg_t c);
		write_register(REG_START_FIRST,  CFG_DATA_W'(c.start_first));
		write_register(REG_START_SECOND, CFG_DATA_W'(c.start_second));
		write_register(REG_OWN_ADDRESS,  CFG_DATA_W'(c.own_address));
		write_register(REG_STATIC_CODE,  CFG_DATA_W'(c.static_code));
		write_register(REG_DYNAMIC_CODE, CFG_DATA_W'(c.dynamic_code));
		cfg_if.valid <= 1'b0;
	endtask

	// one frame, mostly well formed with random content; sometimes line noise,
	// a header error, a cut-off frame or a bad checksum
	task automatic send_frame(bit longest);
		logic [BYTE_W-1:0] bytes [$];
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] cmd;
		logic [SUM_W-1:0]  sum;
		int                pick;
		int                len;
		int                count;
		pick = longest ? 99 : $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 4))
				send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), PREDICTED);
			restart_next = 1'b1;
			return;
		end
		if (pick < 14) begin
			send_item(phase_cfg.start_first, 1'b0, PREDICTED);
			send_item(phase_cfg.start_second ^ BYTE_W'($urandom_range(1, 255)), 1'b0,
				PREDICTED);
			items_sent += 2;
			return;
		end

		case ($urandom_range(0, 6))
			0, 1, 2, 3: addr = phase_cfg.own_address;
			4:          addr = phase_cfg.own_address ^ (ADDR_W'(1) << $urandom_range(0, 15));
			default:    addr = ADDR_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2:    cmd = phase_cfg.static_code;
			3, 4, 5, 6: cmd = phase_cfg.dynamic_code;
			default:    cmd = BYTE_W'($urandom_range(0, 255));
		endcase
		if (longest) begin
			len = 255;
			addr = phase_cfg.own_address;
		end else begin
			len = $urandom_range(0, 99);
			len = (len < 2) ? 255 : (len < 60) ? $urandom_range(0, 3) : $urandom_range(4, 24);
		end

		bytes = '{phase_cfg.start_first, phase_cfg.start_second, addr[BYTE_W-1:0],
			addr[ADDR_W-1:BYTE_W], cmd, BYTE_W'(len)};
		repeat (len) bytes.push_back(BYTE_W'($urandom_range(0, 255)));
		sum = '0;
		foreach (bytes[i]) sum += SUM_W'(bytes[i]);
		if (!longest && $urandom_range(0, 9) == 0)
			sum ^= SUM_W'($urandom_range(1, 65535));
		bytes.push_back(sum[BYTE_W-1:0]);
		bytes.push_back(sum[SUM_W-1:BYTE_W]);

		count = bytes.size();
		if (!longest && pick >= 92) begin
			// cut off; the next byte carries a restart
			count        = $urandom_range(1, bytes.size() - 1);
			restart_next = 1'b1;
		end
		for (int i = 0; i < count; i++)
			send_item(bytes[i], ($urandom_range(0, 299) == 0), PREDICTED);
		items_sent += count;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int phase;
		int frames;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		rx_if.restart = 1'b0;
		cfg_if.valid  = 1'b0;
		cfg_if.index  = REG_START_FIRST;
		cfg_if.data   = '0;
		model_regs    = '0;
		phase_cfg     = '0;
		clear_frame();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == FIRST_CONFIGURED_ROW) begin
				finish_outstanding();
				phase_cfg = DIRECTED_CFG;
				load_registers(phase_cfg);
			end
			send_item(DIRECTED[i].data, DIRECTED[i].rs,
				'{fixed: DIRECTED[i].fixed, value: DIRECTED[i].value});
		end

		phase = 0;
		// the long hold-off phase always runs
		while (items_sent < ITEM_TARGET || phase <= 2) begin
			// sender waits for every result before the registers change
			finish_outstanding();
			case (phase)
				0: phase_cfg = '0;
				1: phase_cfg = '1;  // all extremes, request codes equal
				default: begin
					phase_cfg.start_first  = BYTE_W'($urandom_range(0, 255));
					phase_cfg.start_second = BYTE_W'($urandom_range(0, 255));
					phase_cfg.own_address  = ADDR_W'($urandom_range(0, 65535));
					phase_cfg.static_code  = BYTE_W'($urandom_range(0, 255));
					phase_cfg.dynamic_code = ($urandom_range(0, 3) == 0) ?
						phase_cfg.static_code : BYTE_W'($urandom_range(0, 255));
				end
			endcase
			load_registers(phase_cfg);
			steady_sender = (phase % 3 == 1);
			consumer_hold <= (phase == 2);
			frames = $urandom_range(8, 20);
			for (int f = 0; f < frames; f++)
				send_frame((phase == 2 || phase == 5) && f == 0);
			phase++;
		end

		finish_outstanding();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
